// ===== src/qrv_pkg.sv =====
package qrv_pkg;

  // Pipeline geometry: eight arithmetic stages, one stage per quotient bit, output register.
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned NumStages = 8 + DivSteps + 1;
  localparam int unsigned LastStage = NumStages - 1;

  localparam logic [31:0] NormEpsilonReset = 32'd4295;
  localparam logic [31:0] PosLimit         = 32'h7FFF_FFFF;
  localparam logic [31:0] NegLimit         = 32'h8000_0000;

  typedef logic signed [63:0] prod_t;   // quaternion pair product
  typedef logic signed [65:0] coef_t;   // rotation matrix coefficient times n2
  typedef logic signed [65:0] plo_t;    // coefficient low half times vector
  typedef logic signed [64:0] phi_t;    // coefficient high half times vector
  typedef logic signed [97:0] term_t;
  typedef logic signed [98:0] num_t;
  typedef logic        [97:0] mag_t;
  typedef logic        [64:0] n2_t;
  typedef logic        [65:0] den_t;
  typedef logic        [98:0] rem_t;

  typedef struct packed {
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic               degenerate;
    logic               saturated;
  } out_item_t;

  // Per-item sideband that rides along the pipeline.
  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic               degenerate;
    logic [2:0]         neg;
    logic [2:0]         ovf;
    n2_t                n2;
    den_t               den;
  } side_t;

endpackage

// ===== src/quat_rotate_vector_unit.sv =====
// Rotates a Q16.16 vector by a Q16.16 quaternion that need not be normalized: each
// result component is the vector part of q*v*conj(q) divided by n2 = |q|^2, computed
// exactly and rounded once to nearest (ties away from zero), then clamped to 32 bits
// with the saturated flag set if any component clamps. When n2 is at or below
// norm_epsilon (units of 2^-32, reset 4295) the vector passes unchanged and degenerate
// is set. One item is accepted every cycle; a stall on the output freezes the whole
// pipeline, so a transfer is never lost or repeated. Stages: eight arithmetic (pair
// products, coefficients, split 33x32 multiplies, terms, sums, magnitude, rounding
// bias, overflow check), 32 restoring-division, one per quotient bit, and the output
// register. The user must write norm_epsilon only while idle; the block does not check.
module quat_rotate_vector_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                norm_epsilon_we_i,
  input  logic [31:0]         norm_epsilon_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  qrv_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output qrv_pkg::out_item_t  out_item_o
);

  logic [31:0] norm_epsilon_q;
  logic        valid_q [qrv_pkg::NumStages];
  logic        adv;

  qrv_pkg::side_t side_q [qrv_pkg::LastStage];
  qrv_pkg::side_t side_d [qrv_pkg::LastStage];

  // stage 1: pair products
  qrv_pkg::prod_t p_xx_q, p_yy_q, p_zz_q, p_ww_q;
  qrv_pkg::prod_t p_xy_q, p_xz_q, p_yz_q, p_wx_q, p_wy_q, p_wz_q;
  // stage 2: coefficients and their vector operands, [component][term]
  qrv_pkg::coef_t    coef_q [3][3];
  logic signed [31:0] mv_q  [3][3];
  // stage 3: split products
  qrv_pkg::plo_t plo_q [3][3];
  qrv_pkg::phi_t phi_q [3][3];
  // stage 4..7
  qrv_pkg::term_t term_q [3][3];
  qrv_pkg::num_t  num_q  [3];
  qrv_pkg::mag_t  mag_q  [3];
  qrv_pkg::rem_t  n_q    [3];
  // stage 8 onward: restoring division
  qrv_pkg::rem_t  rem_q  [qrv_pkg::DivSteps + 1][3];
  logic [31:0]    quot_q [qrv_pkg::DivSteps + 1][3];

  qrv_pkg::out_item_t out_q;

  // Whole pipeline advances unless the output holds an untaken result.
  assign adv         = !valid_q[qrv_pkg::LastStage] || !out_stall_i;
  assign in_stall_o  = !adv;
  assign out_valid_o = valid_q[qrv_pkg::LastStage];
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_epsilon_q <= qrv_pkg::NormEpsilonReset;
    end else if (norm_epsilon_we_i) begin
      norm_epsilon_q <= norm_epsilon_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < qrv_pkg::NumStages; k++) valid_q[k] <= 1'b0;
    end else if (adv) begin
      valid_q[0] <= in_valid_i;
      for (int k = 1; k < qrv_pkg::NumStages; k++) valid_q[k] <= valid_q[k-1];
    end
  end

  // Sideband: shift along, then fill fields at the stage that knows them.
  always_comb begin
    side_d[0]       = '0;
    side_d[0].vec_x = in_item_i.vec_x;
    side_d[0].vec_y = in_item_i.vec_y;
    side_d[0].vec_z = in_item_i.vec_z;
    for (int k = 1; k < qrv_pkg::LastStage; k++) side_d[k] = side_q[k-1];
    side_d[1].n2         = qrv_pkg::n2_t'(p_xx_q) + qrv_pkg::n2_t'(p_yy_q)
                         + qrv_pkg::n2_t'(p_zz_q) + qrv_pkg::n2_t'(p_ww_q);
    side_d[2].degenerate = !side_q[1].n2[64]
                           && (side_q[1].n2[63:0] <= {32'd0, norm_epsilon_q});
    for (int c = 0; c < 3; c++) side_d[5].neg[c] = num_q[c][98];
    side_d[6].den        = {side_q[5].n2, 1'b0};
    for (int c = 0; c < 3; c++) begin
      side_d[7].ovf[c] = n_q[c] >= ((qrv_pkg::rem_t'(side_q[6].den) << 31)
                       + (side_q[6].neg[c] ? qrv_pkg::rem_t'(side_q[6].den) : '0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < qrv_pkg::LastStage; k++) side_q[k] <= side_d[k];
    end
  end

  // Arithmetic stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_xx_q <= $signed(in_item_i.quat_x) * $signed(in_item_i.quat_x);
      p_yy_q <= $signed(in_item_i.quat_y) * $signed(in_item_i.quat_y);
      p_zz_q <= $signed(in_item_i.quat_z) * $signed(in_item_i.quat_z);
      p_ww_q <= $signed(in_item_i.quat_w) * $signed(in_item_i.quat_w);
      p_xy_q <= $signed(in_item_i.quat_x) * $signed(in_item_i.quat_y);
      p_xz_q <= $signed(in_item_i.quat_x) * $signed(in_item_i.quat_z);
      p_yz_q <= $signed(in_item_i.quat_y) * $signed(in_item_i.quat_z);
      p_wx_q <= $signed(in_item_i.quat_w) * $signed(in_item_i.quat_x);
      p_wy_q <= $signed(in_item_i.quat_w) * $signed(in_item_i.quat_y);
      p_wz_q <= $signed(in_item_i.quat_w) * $signed(in_item_i.quat_z);

      // x' = A vx + 2(xy-wz) vy + 2(xz+wy) vz, and likewise for y', z'
      coef_q[0][0] <= qrv_pkg::coef_t'(p_ww_q) + qrv_pkg::coef_t'(p_xx_q)
                    - qrv_pkg::coef_t'(p_yy_q) - qrv_pkg::coef_t'(p_zz_q);
      coef_q[0][1] <= (qrv_pkg::coef_t'(p_xy_q) - qrv_pkg::coef_t'(p_wz_q)) <<< 1;
      coef_q[0][2] <= (qrv_pkg::coef_t'(p_xz_q) + qrv_pkg::coef_t'(p_wy_q)) <<< 1;
      coef_q[1][0] <= qrv_pkg::coef_t'(p_ww_q) - qrv_pkg::coef_t'(p_xx_q)
                    + qrv_pkg::coef_t'(p_yy_q) - qrv_pkg::coef_t'(p_zz_q);
      coef_q[1][1] <= (qrv_pkg::coef_t'(p_xy_q) + qrv_pkg::coef_t'(p_wz_q)) <<< 1;
      coef_q[1][2] <= (qrv_pkg::coef_t'(p_yz_q) - qrv_pkg::coef_t'(p_wx_q)) <<< 1;
      coef_q[2][0] <= qrv_pkg::coef_t'(p_ww_q) - qrv_pkg::coef_t'(p_xx_q)
                    - qrv_pkg::coef_t'(p_yy_q) + qrv_pkg::coef_t'(p_zz_q);
      coef_q[2][1] <= (qrv_pkg::coef_t'(p_xz_q) - qrv_pkg::coef_t'(p_wy_q)) <<< 1;
      coef_q[2][2] <= (qrv_pkg::coef_t'(p_yz_q) + qrv_pkg::coef_t'(p_wx_q)) <<< 1;
      mv_q[0][0] <= side_q[0].vec_x;
      mv_q[0][1] <= side_q[0].vec_y;
      mv_q[0][2] <= side_q[0].vec_z;
      mv_q[1][0] <= side_q[0].vec_y;
      mv_q[1][1] <= side_q[0].vec_x;
      mv_q[1][2] <= side_q[0].vec_z;
      mv_q[2][0] <= side_q[0].vec_z;
      mv_q[2][1] <= side_q[0].vec_x;
      mv_q[2][2] <= side_q[0].vec_y;

      // 66-bit coefficient split into signed high and unsigned low 33-bit halves
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < 3; j++) begin
          plo_q[c][j]  <= $signed({1'b0, coef_q[c][j][32:0]}) * mv_q[c][j];
          phi_q[c][j]  <= $signed(coef_q[c][j][65:33]) * mv_q[c][j];
          term_q[c][j] <= (qrv_pkg::term_t'(phi_q[c][j]) <<< 33)
                        + qrv_pkg::term_t'(plo_q[c][j]);
        end
        num_q[c] <= qrv_pkg::num_t'(term_q[c][0]) + qrv_pkg::num_t'(term_q[c][1])
                  + qrv_pkg::num_t'(term_q[c][2]);
        mag_q[c] <= num_q[c][98] ? qrv_pkg::mag_t'(-num_q[c]) : qrv_pkg::mag_t'(num_q[c]);
        // round to nearest: (2|num| + n2) / (2 n2)
        n_q[c]       <= {mag_q[c], 1'b0} + qrv_pkg::rem_t'(side_q[5].n2);
      end
    end
  end

  // One quotient bit per stage, most significant first.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        rem_q[0][c]  <= n_q[c];
        quot_q[0][c] <= '0;
      end
      for (int k = 0; k < qrv_pkg::DivSteps; k++) begin
        for (int c = 0; c < 3; c++) begin
          if (rem_q[k][c] >= (qrv_pkg::rem_t'(side_q[7+k].den) << (qrv_pkg::DivSteps-1-k)))
          begin
            rem_q[k+1][c] <= rem_q[k][c]
                           - (qrv_pkg::rem_t'(side_q[7+k].den) << (qrv_pkg::DivSteps-1-k));
            quot_q[k+1][c] <= quot_q[k][c] | (32'd1 << (qrv_pkg::DivSteps-1-k));
          end else begin
            rem_q[k+1][c]  <= rem_q[k][c];
            quot_q[k+1][c] <= quot_q[k][c];
          end
        end
      end
    end
  end

  // Output register: identity, clamp, or signed quotient.
  logic [31:0] rot_d [3];
  logic [31:0] vec_pass [3];

  assign vec_pass[0] = side_q[qrv_pkg::LastStage-1].vec_x;
  assign vec_pass[1] = side_q[qrv_pkg::LastStage-1].vec_y;
  assign vec_pass[2] = side_q[qrv_pkg::LastStage-1].vec_z;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (side_q[qrv_pkg::LastStage-1].degenerate) begin
        rot_d[c] = vec_pass[c];
      end else if (side_q[qrv_pkg::LastStage-1].ovf[c]) begin
        rot_d[c] = side_q[qrv_pkg::LastStage-1].neg[c] ? qrv_pkg::NegLimit
                                                       : qrv_pkg::PosLimit;
      end else if (side_q[qrv_pkg::LastStage-1].neg[c]) begin
        rot_d[c] = 32'd0 - quot_q[qrv_pkg::DivSteps][c];
      end else begin
        rot_d[c] = quot_q[qrv_pkg::DivSteps][c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.rot_x      <= rot_d[0];
      out_q.rot_y      <= rot_d[1];
      out_q.rot_z      <= rot_d[2];
      out_q.degenerate <= side_q[qrv_pkg::LastStage-1].degenerate;
      out_q.saturated  <= !side_q[qrv_pkg::LastStage-1].degenerate
                          && (|side_q[qrv_pkg::LastStage-1].ovf);
    end
  end

  // identity results never report a clamp
  a_deg_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.degenerate |-> !out_item_o.saturated)
    else $error("degenerate result flagged saturated");

  // an accepted transfer enters the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> valid_q[0])
    else $error("accepted item missing from first stage");

  // a held output freezes the first and middle stages and stays valid
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(valid_q[0]) && $stable(valid_q[qrv_pkg::LastStage/2])
                                   && out_valid_o)
    else $error("pipeline moved while output held");

endmodule
